// ===== src/rcvc_pkg.sv =====
package rcvc_pkg;

    localparam int unsigned InWidth   = 96;
    localparam int unsigned OutWidth  = 32;
    localparam int unsigned AddrWidth = 5;

    localparam logic [8:0]  FreqMin    = 9'd120;
    localparam logic [8:0]  FreqMax    = 9'd320;
    localparam logic [12:0] OpenMax    = 13'd8000;
    localparam logic [12:0] OpenInit   = 13'd4000;
    localparam logic [11:0] HighPLimit = 12'd1120;
    localparam logic [11:0] LowPLimit  = 12'd320;

    localparam logic [1:0] ActHold = 2'd0;
    localparam logic [1:0] ActBand = 2'd1;
    localparam logic [1:0] ActSh   = 2'd2;

    localparam logic [2:0] RegSetTemp   = 3'd0;
    localparam logic [2:0] RegBandLow   = 3'd1;
    localparam logic [2:0] RegBandHigh  = 3'd2;
    localparam logic [2:0] RegBandTgt   = 3'd3;
    localparam logic [2:0] RegGainDiff  = 3'd4;
    localparam logic [2:0] RegGainSh    = 3'd5;
    localparam logic [2:0] RegShMin     = 3'd6;
    localparam logic [2:0] RegExhLimit  = 3'd7;

    typedef struct packed {
        logic [11:0]        low_pressure;
        logic [11:0]        high_pressure;
        logic signed [12:0] saturation_temp;
        logic signed [12:0] exhaust_temp;
        logic signed [12:0] suct_temp;
        logic signed [12:0] evaporator_temp;
        logic signed [12:0] cab_temp;
    } t_in_item;

    typedef struct packed {
        logic        superheat_alarm;
        logic        low_pressure_alarm;
        logic        high_pressure_alarm;
        logic        exhaust_alarm;
        logic [1:0]  valve_action;
        logic [12:0] valve_opening;
        logic signed [2:0] frequency_step;
        logic [8:0]  compressor_hz;
    } t_out_item;

endpackage

// ===== src/refrigeration_compressor_valve_control_top.sv =====
// Compressor frequency and expansion-valve step, one sensor set per item.
// An accepted input item is held in the input register, then its result is
// captured in the result register.
// Throughput: one item per cycle while the output is not stalled; the single gain
// multiplier sits between the input register and the result register.
// Reset (synchronous, active low): frequency 120 Hz, opening 4000,
// configuration registers to their defaults, both stages empty.
module refrigeration_compressor_valve_control_top
    import rcvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // cab_temp, evaporator_temp, suct_temp, exhaust_temp,
    // saturation_temp, high_pressure, low_pressure, zero pad
    input  logic [InWidth-1:0]   i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // compressor_hz, frequency_step, valve_opening, valve_action,
    // exhaust_alarm, high_pressure_alarm, low_pressure_alarm, superheat_alarm, pad
    output logic [OutWidth-1:0]  o_m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic signed [10:0] r_set_temp;
    logic [9:0]         r_band_low, r_band_high, r_band_tgt;
    logic [9:0]         r_gain_diff, r_gain_sh, r_sh_min;
    logic [11:0]        r_exh_limit;

    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;
    logic [8:0]         r_freq;
    logic [12:0]        r_open;

    logic               adv;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic signed [13:0] d;
    logic signed [2:0]  step;
    logic signed [10:0] f_sum;
    logic [8:0]         n_freq;
    logic signed [13:0] diff;
    logic signed [13:0] sh;
    logic signed [14:0] err;
    logic               out_band;
    logic               low_sh;
    logic [1:0]         action;
    logic signed [14:0] opnd;
    logic signed [10:0] gain_s;
    logic signed [25:0] prod;
    logic signed [17:0] delta;
    logic signed [19:0] open_sum;
    logic [12:0]        n_open;
    t_out_item          n_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        unique case (cfg_idx)
            RegSetTemp:  prdata = {{21{r_set_temp[10]}}, r_set_temp};
            RegBandLow:  prdata = {22'd0, r_band_low};
            RegBandHigh: prdata = {22'd0, r_band_high};
            RegBandTgt:  prdata = {22'd0, r_band_tgt};
            RegGainDiff: prdata = {22'd0, r_gain_diff};
            RegGainSh:   prdata = {22'd0, r_gain_sh};
            RegShMin:    prdata = {22'd0, r_sh_min};
            RegExhLimit: prdata = {20'd0, r_exh_limit};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_temp  <= -11'sd160;
            r_band_low  <= 10'd80;
            r_band_high <= 10'd128;
            r_band_tgt  <= 10'd104;
            r_gain_diff <= 10'd128;
            r_gain_sh   <= 10'd205;
            r_sh_min    <= 10'd80;
            r_exh_limit <= 12'd1760;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                RegSetTemp:  r_set_temp  <= pwdata[10:0];
                RegBandLow:  r_band_low  <= pwdata[9:0];
                RegBandHigh: r_band_high <= pwdata[9:0];
                RegBandTgt:  r_band_tgt  <= pwdata[9:0];
                RegGainDiff: r_gain_diff <= pwdata[9:0];
                RegGainSh:   r_gain_sh   <= pwdata[9:0];
                RegShMin:    r_sh_min    <= pwdata[9:0];
                RegExhLimit: r_exh_limit <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // compressor step
    always_comb begin
        d = {r_in.cab_temp[12], r_in.cab_temp} - {{3{r_set_temp[10]}}, r_set_temp};
        priority if (d >= 14'sd80)  step = 3'sd3;
        else if (d >= 14'sd32)      step = 3'sd2;
        else if (d > 14'sd0)        step = 3'sd1;
        else if (d <= -14'sd80)     step = -3'sd3;
        else if (d <= -14'sd32)     step = -3'sd2;
        else if (d < 14'sd0)        step = -3'sd1;
        else                        step = 3'sd0;
        f_sum = $signed({2'b00, r_freq}) + {{8{step[2]}}, step};
        if (f_sum < $signed({2'b00, FreqMin})) begin
            n_freq = FreqMin;
        end else if (f_sum > $signed({2'b00, FreqMax})) begin
            n_freq = FreqMax;
        end else begin
            n_freq = f_sum[8:0];
        end
    end

    // valve step, one shared multiplier
    always_comb begin
        diff     = {r_in.cab_temp[12], r_in.cab_temp}
                 - {r_in.evaporator_temp[12], r_in.evaporator_temp};
        sh       = {r_in.suct_temp[12], r_in.suct_temp}
                 - {r_in.saturation_temp[12], r_in.saturation_temp};
        err      = {diff[13], diff} - $signed({5'd0, r_band_tgt});
        out_band = (diff < $signed({4'd0, r_band_low})) ||
                   (diff > $signed({4'd0, r_band_high}));
        low_sh   = sh < $signed({4'd0, r_sh_min});
        if (out_band) begin
            action = ActBand;
            opnd   = err;
            gain_s = $signed({1'b0, r_gain_diff});
        end else begin
            action = low_sh ? ActSh : ActHold;
            opnd   = {sh[13], sh};
            gain_s = $signed({1'b0, r_gain_sh});
        end
        prod     = opnd * gain_s;
        delta    = (action == ActHold) ? 18'sd0 : prod[25:8];
        open_sum = $signed({7'd0, r_open}) - {{2{delta[17]}}, delta};
        if (open_sum < 20'sd0) begin
            n_open = 13'd0;
        end else if (open_sum > $signed({7'd0, OpenMax})) begin
            n_open = OpenMax;
        end else begin
            n_open = open_sum[12:0];
        end
    end

    always_comb begin
        n_out.compressor_hz       = n_freq;
        n_out.frequency_step      = step;
        n_out.valve_opening       = n_open;
        n_out.valve_action        = action;
        n_out.exhaust_alarm       = $signed({r_in.exhaust_temp[12], r_in.exhaust_temp})
                                    >= $signed({2'd0, r_exh_limit});
        n_out.high_pressure_alarm = r_in.high_pressure >= HighPLimit;
        n_out.low_pressure_alarm  = r_in.low_pressure <= LowPLimit;
        n_out.superheat_alarm     = action == ActSh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_freq      <= FreqMin;
            r_open      <= OpenInit;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_freq      <= n_freq;
                r_open      <= n_open;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= i_s_axis_tdata[$bits(t_in_item)-1:0];
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/rcvc_checker.sv =====
module rcvc_checker
    import rcvc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [OutWidth-1:0]  o_m_axis_tdata
);

    t_out_item res;
    assign res = o_m_axis_tdata[$bits(t_out_item)-1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_hz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> res.compressor_hz >= FreqMin && res.compressor_hz <= FreqMax)
        else $error("compressor frequency out of range");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> res.valve_opening <= OpenMax)
        else $error("valve opening out of range");

    a_sh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> res.superheat_alarm == (res.valve_action == ActSh) &&
                            res.valve_action != 2'd3)
        else $error("superheat alarm disagrees with valve action");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> res.frequency_step != -3'sd4)
        else $error("frequency step out of range");

endmodule

bind refrigeration_compressor_valve_control_top rcvc_checker u_rcvc_checker (.*);

// ===== verif/tb_refrigeration_compressor_valve_control_top.sv =====
`timescale 1ns / 1ps

module tb_refrigeration_compressor_valve_control_top;
    import rcvc_pkg::*;

    localparam int StallCycles = 100;
    localparam int QuietLimit  = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               s_tvalid = 1'b0;
    logic [InWidth-1:0] s_tdata = '0;
    logic               m_tready = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;

    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [OutWidth-1:0] o_m_axis_tdata;
    logic [31:0]         prdata;
    logic                pready;

    // model state and settings, reset values
    int cfg_set_temp = -160;
    int cfg_band_low = 80;
    int cfg_band_high = 128;
    int cfg_band_tgt = 104;
    int cfg_gain_diff = 128;
    int cfg_gain_sh = 205;
    int cfg_sh_min = 80;
    int cfg_exh_limit = 1760;
    int hz_q = int'(FreqMin);
    int opening_q = int'(OpenInit);

    t_out_item pending_control[$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int settings_written = 0;
    int quiet_cycles = 0;

    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int stall_req = 0;
    int stall_ack = 0;
    int stall_left = 0;

    refrigeration_compressor_valve_control_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_in_item reading(int cab, int evap, int suct, int exh, int sat,
                                         int hp, int lp);
        t_in_item it;
        it.cab_temp        = 13'(cab);
        it.evaporator_temp = 13'(evap);
        it.suct_temp       = 13'(suct);
        it.exhaust_temp    = 13'(exh);
        it.saturation_temp = 13'(sat);
        it.high_pressure   = 12'(hp);
        it.low_pressure    = 12'(lp);
        return it;
    endfunction

    // one compressor and valve step; advances the model state
    function automatic t_out_item compute_control(t_in_item it);
        t_out_item res;
        int cab, evap, suct, exh, sat, hp, lp;
        int d, step, f, diff, sh;
        logic [1:0] action;
        longint open;
        cab  = int'($signed(it.cab_temp));
        evap = int'($signed(it.evaporator_temp));
        suct = int'($signed(it.suct_temp));
        exh  = int'($signed(it.exhaust_temp));
        sat  = int'($signed(it.saturation_temp));
        hp   = int'(it.high_pressure);
        lp   = int'(it.low_pressure);
        open = opening_q;
        action = ActHold;

        d = cab - cfg_set_temp;
        if (d >= 80) step = 3;
        else if (d >= 32) step = 2;
        else if (d > 0) step = 1;
        else if (d <= -80) step = -3;
        else if (d <= -32) step = -2;
        else if (d < 0) step = -1;
        else step = 0;

        f = hz_q + step;
        if (f < int'(FreqMin)) f = int'(FreqMin);
        if (f > int'(FreqMax)) f = int'(FreqMax);
        hz_q = f;

        diff = cab - evap;
        sh = suct - sat;
        if (diff < cfg_band_low || diff > cfg_band_high) begin
            open = open - ((longint'(cfg_gain_diff) * longint'(diff - cfg_band_tgt)) >>> 8);
            action = ActBand;
        end else if (sh < cfg_sh_min) begin
            open = open - ((longint'(cfg_gain_sh) * longint'(sh)) >>> 8);
            action = ActSh;
        end
        if (open < 0) open = 0;
        if (open > longint'(OpenMax)) open = longint'(OpenMax);
        opening_q = int'(open);

        res.compressor_hz       = 9'(f);
        res.frequency_step      = 3'(step);
        res.valve_opening       = 13'(opening_q);
        res.valve_action        = action;
        res.exhaust_alarm       = exh >= cfg_exh_limit;
        res.high_pressure_alarm = hp >= int'(HighPLimit);
        res.low_pressure_alarm  = lp <= int'(LowPLimit);
        res.superheat_alarm     = action == ActSh;
        return res;
    endfunction

    function automatic int reg_value(int idx);
        int lo, hi, r;
        lo = 0;
        hi = 800;
        case (3'(idx))
            RegSetTemp:             lo = -800;
            RegGainDiff, RegGainSh: hi = 1023;
            RegExhLimit:            hi = 2400;
            default: ;
        endcase
        r = $urandom_range(0, 9);
        if (r < 6) return span(lo, hi);
        if (r == 6) return lo;
        if (r == 7) return hi;
        return int'($urandom);
    endfunction

    // trend: 0 cabinet warm, 1 cabinet cold, 2 near set point
    function automatic t_in_item random_reading(int trend);
        logic [95:0] bits;
        t_in_item it;
        int cab, evap, suct, exh, sat, hp, lp;
        if ($urandom_range(0, 99) < 25) begin
            bits = {$urandom, $urandom, $urandom};
            it = bits[$bits(t_in_item)-1:0];
            return it;
        end
        case (trend)
            0:       cab = cfg_set_temp + span(0, 200);
            1:       cab = cfg_set_temp - span(0, 200);
            default: cab = cfg_set_temp + span(-40, 40);
        endcase
        case ($urandom_range(0, 3))
            0: begin
                if (cfg_band_high >= cfg_band_low) evap = cab - span(cfg_band_low, cfg_band_high);
                else evap = cab - span(0, 800);
            end
            1:       evap = cab - cfg_band_low + span(1, 150);
            2:       evap = cab - cfg_band_high - span(1, 150);
            default: evap = span(-800, 2400);
        endcase
        sat = span(-800, 400);
        suct = sat + cfg_sh_min + span(-150, 60);
        exh = $urandom_range(0, 1) ? cfg_exh_limit + span(-2, 2) : span(-800, 2400);
        hp = $urandom_range(0, 1) ? int'(HighPLimit) + span(-2, 2) : span(0, 2400);
        lp = $urandom_range(0, 1) ? int'(LowPLimit) + span(-2, 2) : span(0, 2400);
        return reading(cab, evap, suct, exh, sat, hp, lp);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    task automatic send_reading(input t_in_item it);
        while (src_idle_en && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= InWidth'(it);
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_control.push_back(compute_control(it));
        items_sent++;
    endtask

    task automatic write_setting(input logic [2:0] idx, input int value);
        logic [31:0] v;
        v = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            RegSetTemp:  cfg_set_temp = int'($signed(v[10:0]));
            RegBandLow:  cfg_band_low = int'(v[9:0]);
            RegBandHigh: cfg_band_high = int'(v[9:0]);
            RegBandTgt:  cfg_band_tgt = int'(v[9:0]);
            RegGainDiff: cfg_gain_diff = int'(v[9:0]);
            RegGainSh:   cfg_gain_sh = int'(v[9:0]);
            RegShMin:    cfg_sh_min = int'(v[9:0]);
            RegExhLimit: cfg_exh_limit = int'(v[11:0]);
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        settings_written++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        for (int n = 0; n < 400 && pending_control.size() != 0; n++) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic test_threshold_cases();
        int d_steps[11] = '{80, 79, 32, 31, 1, 0, -1, -31, -32, -79, -80};
        int band_edges[4] = '{80, 79, 128, 129};
        int sh_cases[3] = '{79, 80, -200};
        send_reading(reading(-800, -800, -800, -800, -800, 0, 0));
        send_reading(reading(2400, 2400, 2400, 2400, 2400, 2400, 2400));
        send_reading(reading(-4096, 4095, -4096, 4095, 4095, 4095, 0));
        send_reading(reading(-1, -1, -1, -1, -1, 4095, 4095));
        foreach (d_steps[k])
            send_reading(reading(cfg_set_temp + d_steps[k], cfg_set_temp + d_steps[k] - 100,
                                 100, 0, 0, 500, 500));
        foreach (band_edges[k])
            send_reading(reading(-160, -160 - band_edges[k], 100, 0, 0, 500, 500));
        // low superheat, at minimum, negative superheat
        foreach (sh_cases[k])
            send_reading(reading(-160, -260, sh_cases[k], 0, 0, 500, 500));
        send_reading(reading(-160, -260, 100, 1760, 0, 1120, 320));
        send_reading(reading(-160, -260, 100, 1759, 0, 1119, 321));
        settle();
    endtask

    task automatic test_setting_extremes();
        int hi_set[8] = '{800, 800, 800, 800, 1023, 1023, 800, 2400};
        int lo_set[8] = '{-800, 0, 0, 0, 0, 0, 0, 0};
        int inv_set[8] = '{0, 600, 100, 350, 512, 300, 200, 1000};
        for (int p = 0; p < 4; p++) begin
            for (int r = 0; r < 8; r++)
                write_setting(3'(r), p == 0 ? hi_set[r] : p == 1 ? lo_set[r] :
                                     p == 2 ? inv_set[r] : reg_value(r));
            repeat (25) send_reading(random_reading(p % 3));
            settle();
        end
    endtask

    task automatic test_random_stream();
        int trend;
        trend = 2;
        for (int n = 0; n < 480; n++) begin
            if (n % 40 == 0) trend = $urandom_range(0, 2);
            if (n > 0 && n % 80 == 0) begin
                settle();
                for (int r = 0; r < 8; r++)
                    if ($urandom_range(0, 1)) write_setting(3'(r), reg_value(r));
            end
            src_idle_en = !(n >= 200 && n < 300);
            sink_idle_en = src_idle_en;
            send_reading(random_reading(trend));
        end
        settle();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_input_stall();
        src_idle_en = 1'b0;
        stall_req++;
        repeat (40) send_reading(random_reading($urandom_range(0, 2)));
        settle();
        src_idle_en = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (stall_req != stall_ack) begin
            stall_ack <= stall_req;
            stall_left <= StallCycles;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(sink_idle_en && $urandom_range(0, 99) < 13);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item got, want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = o_m_axis_tdata[$bits(t_out_item)-1:0];
            results_seen++;
            if (pending_control.size() == 0) begin
                flag_mismatch("result with nothing pending", got, 0);
            end else begin
                want = pending_control.pop_front();
                if (got.compressor_hz != want.compressor_hz)
                    flag_mismatch("compressor_hz", got.compressor_hz, want.compressor_hz);
                if (got.frequency_step != want.frequency_step)
                    flag_mismatch("frequency_step", got.frequency_step, want.frequency_step);
                if (got.valve_opening != want.valve_opening)
                    flag_mismatch("valve_opening", got.valve_opening, want.valve_opening);
                if (got.valve_action != want.valve_action)
                    flag_mismatch("valve_action", got.valve_action, want.valve_action);
                if (got.exhaust_alarm != want.exhaust_alarm)
                    flag_mismatch("exhaust_alarm", got.exhaust_alarm, want.exhaust_alarm);
                if (got.high_pressure_alarm != want.high_pressure_alarm)
                    flag_mismatch("high_pressure_alarm", got.high_pressure_alarm,
                                  want.high_pressure_alarm);
                if (got.low_pressure_alarm != want.low_pressure_alarm)
                    flag_mismatch("low_pressure_alarm", got.low_pressure_alarm,
                                  want.low_pressure_alarm);
                if (got.superheat_alarm != want.superheat_alarm)
                    flag_mismatch("superheat_alarm", got.superheat_alarm, want.superheat_alarm);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready) ||
            (psel && penable) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("Watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_threshold_cases();
        test_setting_extremes();
        test_random_stream();
        test_input_stall();

        settle();
        if (pending_control.size() != 0)
            flag_mismatch("results never delivered", 0, pending_control.size());

        $display("Ran %0d sensor sets through %0d register writes, checked %0d results.",
                 items_sent, settings_written, results_seen);
        $display("Covered step and band edges, low superheat, alarms, settings, stalls; %0d bad.",
                 mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
